@@ rtl/pressure_frame_parser_top_macros.svh @@
// Assertion macros for the pressure frame parser.
// Used by rtl/pfp_core.sv; expects i_clk and i_rst_n in the including module.
`ifndef PRESSURE_FRAME_PARSER_TOP_MACROS_SVH
`define PRESSURE_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define PFP_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pfp assertion failed");
// checked at every edge, reset included
`define PFP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("pfp reset assertion failed");
`else
`define PFP_ASSERT(label, prop)
`define PFP_ASSERT_RST(label, prop)
`endif

`endif

@@ rtl/pfp_pkg.sv @@
// Shared types and constants of the pressure frame parser.
// No dependencies; imported by all pfp modules.
package pfp_pkg;

    localparam int DEF_FRAME_CHARS = 7;  // stored characters per frame
    localparam int OUT_CHARS       = 7;  // characters in a result
    localparam int SEP_W           = 3;  // separator position width
    localparam int SEP_SAT         = 7;  // separator position saturates here
    localparam int MIN_LEN         = 3;  // shortest frame text
    localparam int MAX_SEP         = 3;  // last allowed separator position
    localparam int AFTER_MIN       = 2;  // separator plus 1..3 digits
    localparam int AFTER_MAX       = 4;

    localparam logic [7:0] CH_START = 8'h3B;  // ';'
    localparam logic [7:0] CH_END   = 8'h3A;  // ':'
    localparam logic [7:0] CH_SEP   = 8'h78;  // 'x'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

    localparam logic STATUS_ERROR = 1'b0;
    localparam logic STATUS_OK    = 1'b1;

    typedef logic [OUT_CHARS-1:0][7:0] t_text;

    // element 0 is the first character: "ERRO!  "
    localparam t_text ERR_TEXT = {CH_SPACE, CH_SPACE, 8'h21, 8'h4F, 8'h52, 8'h52, 8'h45};

    typedef struct packed {
        logic  status;
        t_text text;
    } t_result;

endpackage

@@ rtl/pfp_in_reg.sv @@
// Input register of the pressure frame parser: holds one received byte.
// Depends on pfp_pkg.
module pfp_in_reg
    import pfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

@@ rtl/pfp_core.sv @@
// Frame state and per-byte checks of the pressure frame parser.
// Depends on pfp_pkg and pressure_frame_parser_top_macros.svh.
`include "pressure_frame_parser_top_macros.svh"

module pfp_core
    import pfp_pkg::*;
#(
    parameter int FRAME_CHARS = DEF_FRAME_CHARS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_result
);

    localparam int CW = $clog2(FRAME_CHARS + 1);
    localparam int IW = (FRAME_CHARS > 1) ? $clog2(FRAME_CHARS) : 1;

    logic             r_in_frame, n_in_frame;
    logic [CW-1:0]    r_count, n_count;
    logic             r_too_long, n_too_long;
    logic [SEP_W-1:0] r_sep, n_sep;
    logic [7:0]       r_chars [FRAME_CHARS];
    logic [7:0]       n_chars [FRAME_CHARS];

    logic [SEP_W-1:0] w_sep_sat;
    logic [4:0]       w_n5, w_s5, w_after5, w_idx5;
    logic             w_frame_ok;
    t_text            w_text;

    // position of an 'x' stored now
    assign w_sep_sat = (int'(r_count) > SEP_SAT) ? SEP_W'(SEP_SAT) : SEP_W'(r_count);

    assign w_n5     = 5'(r_count);
    assign w_s5     = 5'(r_sep);
    assign w_after5 = w_n5 - w_s5;
    assign w_idx5   = w_s5 + 5'd1;

    assign w_frame_ok = !r_too_long
                     && (w_n5 >= 5'(MIN_LEN)) && (w_n5 <= 5'(FRAME_CHARS))
                     && (w_s5 != 5'd0) && (w_s5 <= 5'(MAX_SEP)) && (w_n5 > w_s5)
                     && (w_after5 >= 5'(AFTER_MIN)) && (w_after5 <= 5'(AFTER_MAX))
                     && (r_chars[0] != CH_MINUS)
                     && !((w_idx5 < 5'(FRAME_CHARS))
                          && (r_chars[w_idx5[IW-1:0]] == CH_MINUS));

    for (genvar gi = 0; gi < OUT_CHARS; gi++) begin : g_text
        if (gi < FRAME_CHARS) begin : g_stored
            assign w_text[gi] = r_chars[gi];
        end else begin : g_pad
            assign w_text[gi] = CH_SPACE;
        end
    end

    always_comb begin
        n_in_frame      = r_in_frame;
        n_count         = r_count;
        n_too_long      = r_too_long;
        n_sep           = r_sep;
        n_chars         = r_chars;
        o_res_valid     = 1'b0;
        o_result.status = STATUS_ERROR;
        o_result.text   = ERR_TEXT;
        if (i_step) begin
            if (i_byte == CH_START) begin
                // open or restart; restart inside a frame is an error
                o_res_valid = r_in_frame;
                n_in_frame  = 1'b1;
                n_count     = '0;
                n_too_long  = 1'b0;
                n_sep       = '0;
                for (int i = 0; i < FRAME_CHARS; i++) begin
                    n_chars[i] = CH_SPACE;
                end
            end else if (!r_in_frame) begin
                o_res_valid = 1'b1;
            end else if (i_byte != CH_END) begin
                if (i_byte == CH_SEP) begin
                    n_sep = w_sep_sat;
                end
                if (r_count < CW'(FRAME_CHARS)) begin
                    n_chars[r_count[IW-1:0]] = i_byte;
                    n_count = r_count + CW'(1);
                end else begin
                    n_too_long = 1'b1;
                end
            end else begin
                o_res_valid = 1'b1;
                if (w_frame_ok) begin
                    o_result.status = STATUS_OK;
                    o_result.text   = w_text;
                end
                n_in_frame = 1'b0;
                n_count    = '0;
                n_too_long = 1'b0;
                n_sep      = '0;
                for (int i = 0; i < FRAME_CHARS; i++) begin
                    n_chars[i] = CH_SPACE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_too_long <= 1'b0;
            r_sep      <= '0;
            for (int i = 0; i < FRAME_CHARS; i++) begin
                r_chars[i] <= CH_SPACE;
            end
        end else begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_too_long <= n_too_long;
            r_sep      <= n_sep;
            r_chars    <= n_chars;
        end
    end

    `PFP_ASSERT_RST(a_rst_clears, !i_rst_n |=> (!r_in_frame && r_count == '0))
    `PFP_ASSERT(a_count_max, r_count <= CW'(FRAME_CHARS))
    `PFP_ASSERT(a_too_long_full, r_too_long |-> (r_count == CW'(FRAME_CHARS)))
    `PFP_ASSERT(a_idle_clear, !r_in_frame |-> (r_count == '0 && !r_too_long && r_sep == '0))
    `PFP_ASSERT(a_ok_on_end, (o_res_valid && o_result.status == STATUS_OK) |-> (r_in_frame && i_byte == CH_END))

endmodule

@@ rtl/pfp_out_reg.sv @@
// Result register of the pressure frame parser.
// Depends on pfp_pkg.
module pfp_out_reg
    import pfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/pressure_frame_parser_top.sv @@
// Top level of the pressure frame parser: input register, frame core, result register.
// Depends on pfp_pkg, pfp_in_reg, pfp_core, pfp_out_reg.
//
//   channel   direction  handshake                  payload
//   rx        in         i_rx_valid / o_rx_ready    i_rx_byte
//   res       out        o_res_valid / i_res_ready  o_frame_status, o_text_char_0..6
//
// One byte per cycle sustained while results are taken. A byte is held in the input
// register while the frame checks run; the result register then loads its result.
// Bytes inside an open frame other than start and end bytes, and a start byte outside
// a frame, give no result transaction; every other byte gives one. A stalled result
// holds the byte behind it in the input register; rx ready drops only while both
// registers are full and the result is not taken. Reset (i_rst_n low, synchronous)
// empties both registers and closes any open frame.
module pressure_frame_parser_top
    import pfp_pkg::*;
#(
    parameter int FRAME_CHARS = DEF_FRAME_CHARS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_frame_status,
    output logic [7:0] o_text_char_0,
    output logic [7:0] o_text_char_1,
    output logic [7:0] o_text_char_2,
    output logic [7:0] o_text_char_3,
    output logic [7:0] o_text_char_4,
    output logic [7:0] o_text_char_5,
    output logic [7:0] o_text_char_6
);

    logic       w_byte_valid;
    logic [7:0] w_byte;
    logic       w_out_space;
    logic       w_step;       // byte leaves the input register this cycle
    logic       w_res_load;
    t_result    w_res_next;
    t_result    w_res;

    // a byte advances whenever the result register can take what it may produce
    assign w_step = w_byte_valid && w_out_space;

    pfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .o_ready (o_rx_ready),
        .i_byte  (i_rx_byte),
        .o_valid (w_byte_valid),
        .o_byte  (w_byte),
        .i_take  (w_step)
    );

    pfp_core #(
        .FRAME_CHARS (FRAME_CHARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (w_byte),
        .o_res_valid (w_res_load),
        .o_result    (w_res_next)
    );

    pfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_load),
        .i_result (w_res_next),
        .o_space  (w_out_space),
        .o_valid  (o_res_valid),
        .i_ready  (i_res_ready),
        .o_result (w_res)
    );

    // result text fans out to one port per character
    assign o_frame_status = w_res.status;
    assign o_text_char_0  = w_res.text[0];
    assign o_text_char_1  = w_res.text[1];
    assign o_text_char_2  = w_res.text[2];
    assign o_text_char_3  = w_res.text[3];
    assign o_text_char_4  = w_res.text[4];
    assign o_text_char_5  = w_res.text[5];
    assign o_text_char_6  = w_res.text[6];

endmodule
